@@ hw/rtl/dhst_pkg.sv @@
`default_nettype none
package dhst_pkg;

    // Table geometry
    localparam int TABLE_SIZE = 1021;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int KEY_W      = 31;
    localparam int PW_W       = 64;
    localparam int Q_W        = 10;
    localparam logic [Q_W-1:0] Q_RESET = Q_W'(7);

    // Operation codes
    localparam logic [1:0] KIND_SIGNUP = 2'd0;
    localparam logic [1:0] KIND_LOGIN  = 2'd1;
    localparam logic [1:0] KIND_LOGOUT = 2'd2;
    localparam logic [1:0] KIND_REMOVE = 2'd3;

    // Result codes
    localparam logic [2:0] ST_SUBMIT  = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_QUIT    = 3'd2;
    localparam logic [2:0] ST_NONE    = 3'd3;
    localparam logic [2:0] ST_REMOVED = 3'd4;

    // Slot marks
    localparam logic [1:0] MARK_EMPTY   = 2'd0;
    localparam logic [1:0] MARK_USED    = 2'd1;
    localparam logic [1:0] MARK_DELETED = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [KEY_W-1:0] key;
        logic [PW_W-1:0]  password;
    } t_in;

    typedef struct packed {
        logic [2:0]      status;
        logic [PW_W-1:0] value_out;
    } t_out;

    typedef struct packed {
        logic [1:0]       mark;
        logic             session;
        logic [KEY_W-1:0] key;
        logic [PW_W-1:0]  value;
    } t_slot;

    // Controller to datapath
    typedef struct packed {
        logic clear;
        logic accept;
        logic div;
        logic init;
        logic read;
        logic check;
        logic finish;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_done;
        logic div_done;
        logic chk_end;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

@@ hw/rtl/double_hash_session_table.sv @@
`default_nettype none
// Channel   Signals                               Moves
// in        i_in_valid, o_in_stall, i_in_data     request: kind, key, password
// out       o_out_valid, i_out_stall, o_out_data  result: status, value_out
// cfg       i_cfg_valid, o_cfg_ready, i_cfg_data  step_q write
//
// A request passes through these steps: the accept, a bit-serial remainder
// of the key for the step (the home slot is folded alongside), one set-up step,
// one memory read and one check per probe, then one write-back that waits for a
// free output register. After reset a clearing pass marks every slot empty;
// no request is taken meanwhile. A stalled result holds in the output
// register while the next request is accepted and worked on.
module double_hash_session_table
    import dhst_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire t_in             i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output t_out                 o_out_data,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [Q_W-1:0]  i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    dhst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dhst_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

@@ hw/rtl/dhst_ram.sv @@
`default_nettype none
module dhst_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic                 i_re,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];

    // Write one word, read one word registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/dhst_datapath.sv @@
`default_nettype none
module dhst_datapath
    import dhst_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_cmd            i_cmd,
    output t_sts                 o_sts,
    input  wire t_in             i_in_data,
    input  wire logic            i_cfg_we,
    input  wire logic [Q_W-1:0]  i_cfg_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output t_out                 o_out_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
    localparam logic [IDX_W:0]   SIZE_X   = (IDX_W + 1)'(TABLE_SIZE);
    localparam logic [Q_W-1:0]   STEP_LIM = Q_W'(TABLE_SIZE);

    logic [Q_W-1:0]   r_q;
    t_in              r_item;
    logic [KEY_W-1:0] r_kshift;
    logic [4:0]       r_dcnt;
    logic [13:0]      r_fold;
    logic [IDX_W-1:0] r_rem_t;
    logic [Q_W-1:0]   r_rem_q;
    logic [Q_W-1:0]   r_step;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_n;
    logic             r_hit;
    t_slot            r_hit_slot;
    logic             r_free_ok;
    logic [IDX_W-1:0] r_free_idx;
    logic             r_out_valid;
    t_out             r_out;

    logic [Q_W-1:0]   q_eff;
    logic [Q_W:0]     sh_q;
    logic [13:0]      fold1;
    logic [IDX_W:0]   fold2;
    logic [IDX_W-1:0] n_rem_t;
    logic [Q_W-1:0]   n_rem_q;
    logic [Q_W-1:0]   step_raw;
    logic [Q_W-1:0]   n_step;
    logic [IDX_W:0]   sum;
    logic [IDX_W-1:0] n_idx;
    t_slot            rd;
    logic             is_used;
    logic             hit;
    logic             last;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_slot            ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic             emit;
    t_out             res;
    logic             fin_we;
    logic [IDX_W-1:0] fin_addr;
    t_slot            fin_data;

    // Zero modulus acts as one
    assign q_eff = (r_q == '0) ? Q_W'(1) : r_q;

    // One remainder bit per cycle for the step modulus
    always_comb begin
        sh_q    = {r_rem_q, r_kshift[KEY_W-1]};
        n_rem_q = (sh_q >= {1'b0, q_eff}) ? Q_W'(sh_q - {1'b0, q_eff}) : sh_q[Q_W-1:0];
    end

    // Home slot: fold the key in 10-bit digits (1024 is 3 above the table size),
    // fold once more, then trim with one compare and subtract
    always_comb begin
        fold1   = 14'(r_item.key[9:0]) + 14'(r_item.key[19:10]) * 14'd3
                + 14'(r_item.key[29:20]) * 14'd9 + 14'(r_item.key[30]) * 14'd27;
        fold2   = (IDX_W + 1)'(r_fold[9:0]) + (IDX_W + 1)'(r_fold[13:10]) * 11'd3;
        n_rem_t = (fold2 >= SIZE_X) ? IDX_W'(fold2 - SIZE_X) : fold2[IDX_W-1:0];
    end

    // Probe step, brought below the table size
    always_comb begin
        step_raw = q_eff - r_rem_q;
        n_step   = (step_raw >= STEP_LIM) ? step_raw - STEP_LIM : step_raw;
    end

    // Next probe slot, wrapping once
    always_comb begin
        sum   = (IDX_W + 1)'({1'b0, r_idx} + {1'b0, r_step});
        n_idx = (sum >= SIZE_X) ? IDX_W'(sum - SIZE_X) : sum[IDX_W-1:0];
    end

    // Examine the slot just read
    assign is_used = rd.mark == MARK_USED;
    assign hit     = is_used && (rd.key == r_item.key);
    assign last    = r_n == LAST_IDX;

    // Decide result and slot update
    always_comb begin
        emit          = 1'b1;
        res.status    = ST_SUBMIT;
        res.value_out = '0;
        fin_we        = 1'b0;
        fin_addr      = r_idx;
        fin_data      = r_hit_slot;
        case (r_item.kind)
            KIND_SIGNUP: begin
                if (r_hit) begin
                    res.status = ST_INVALID;
                end else if (r_free_ok) begin
                    fin_we   = 1'b1;
                    fin_addr = r_free_idx;
                    fin_data = '{mark: MARK_USED, session: 1'b0, key: r_item.key,
                                 value: r_item.password};
                end
            end
            KIND_LOGIN: begin
                if (!r_hit || r_hit_slot.value != r_item.password) begin
                    res.status = ST_INVALID;
                end else if (r_hit_slot.session) begin
                    res.status = ST_QUIT;
                end else begin
                    fin_we           = 1'b1;
                    fin_data.session = 1'b1;
                end
            end
            KIND_LOGOUT: begin
                if (!r_hit) begin
                    emit = 1'b0;
                end else begin
                    fin_we           = 1'b1;
                    fin_data.session = 1'b0;
                end
            end
            KIND_REMOVE: begin
                if (!r_hit) begin
                    res.status = ST_NONE;
                end else begin
                    res.status       = ST_REMOVED;
                    res.value_out    = r_hit_slot.value;
                    fin_we           = 1'b1;
                    fin_data.mark    = MARK_DELETED;
                    fin_data.session = 1'b0;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Memory port selection
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = fin_addr;
        ram_wdata = fin_data;
        if (i_cmd.clear) begin
            ram_we    = 1'b1;
            ram_waddr = r_idx;
            ram_wdata = '0;
        end else if (i_cmd.finish) begin
            ram_we = fin_we;
        end
        ram_raddr = r_idx;
    end

    dhst_ram #(
        .W ($bits(t_slot)),
        .D (TABLE_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.read),
        .i_raddr (ram_raddr),
        .o_rdata (rd)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q         <= Q_RESET;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_q <= i_cfg_data;
            end
            if (i_cmd.clear) begin
                r_idx <= r_idx + IDX_W'(1);
            end else if (i_cmd.init) begin
                r_idx <= r_rem_t;
            end else if (i_cmd.check && !o_sts.chk_end) begin
                r_idx <= n_idx;
            end
            if (i_cmd.finish && emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item   <= i_in_data;
            r_kshift <= i_in_data.key;
            r_dcnt   <= '0;
            r_rem_q  <= '0;
        end
        if (i_cmd.div) begin
            r_kshift <= {r_kshift[KEY_W-2:0], 1'b0};
            r_dcnt   <= r_dcnt + 5'd1;
            r_fold   <= fold1;
            r_rem_t  <= n_rem_t;
            r_rem_q  <= n_rem_q;
        end
        if (i_cmd.init) begin
            r_step    <= n_step;
            r_n       <= '0;
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
        end
        if (i_cmd.check) begin
            if (!r_free_ok && !is_used) begin
                r_free_ok  <= 1'b1;
                r_free_idx <= r_idx;
            end
            if (hit) begin
                r_hit      <= 1'b1;
                r_hit_slot <= rd;
            end
            r_n <= r_n + IDX_W'(1);
        end
        if (i_cmd.finish && emit) begin
            r_out <= res;
        end
    end

    assign o_sts.clr_done = r_idx == LAST_IDX;
    assign o_sts.div_done = r_dcnt == 5'(KEY_W - 1);
    assign o_sts.chk_end  = (rd.mark == MARK_EMPTY) || hit || last;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

endmodule
`default_nettype wire

@@ hw/rtl/dhst_ctrl.sv @@
`default_nettype none
module dhst_ctrl
    import dhst_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_INIT,
        S_READ,
        S_CHECK,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    // Command decode and next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = S_READ;
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_sts.chk_end ? S_FINISH : S_READ;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = r_state != S_IDLE;

endmodule
`default_nettype wire

@@ test/dhst_checker.sv @@
`timescale 1ns / 100ps
`default_nettype none
module dhst_checker
    import dhst_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_in_stall,
    input  wire t_in             i_in_data,
    input  wire logic            i_out_valid,
    input  wire logic            i_out_stall,
    input  wire t_out            i_out_data,
    input  wire logic            i_cfg_valid,
    input  wire logic            i_cfg_ready,
    input  wire logic [Q_W-1:0]  i_cfg_data,
    output int                   o_pending,
    output int                   o_errors,
    output int                   o_results
);

    // Shadow of the slot table and the step register
    logic [1:0]       shadow_mark    [TABLE_SIZE];
    logic [KEY_W-1:0] shadow_key     [TABLE_SIZE];
    logic [PW_W-1:0]  shadow_value   [TABLE_SIZE];
    logic             shadow_session [TABLE_SIZE];
    logic [Q_W-1:0]   shadow_q;
    t_out             expected_results [$];

    function automatic int unsigned probe_stride(logic [KEY_W-1:0] k);
        int unsigned q;
        q = (shadow_q == '0) ? 1 : int'(shadow_q);
        return q - (int'(k) % q);
    endfunction

    // Walk the probe sequence; -1 when the key is absent
    function automatic int find_slot(logic [KEY_W-1:0] k);
        int unsigned idx;
        int unsigned stride;
        idx    = int'(k) % TABLE_SIZE;
        stride = probe_stride(k);
        for (int n = 0; n < TABLE_SIZE; n++) begin
            if (shadow_mark[idx] == MARK_EMPTY) return -1;
            if (shadow_mark[idx] == MARK_USED && shadow_key[idx] == k) return int'(idx);
            idx = (idx + stride) % TABLE_SIZE;
        end
        return -1;
    endfunction

    // Place the key in the first slot not in use; drop it on a full table
    function automatic void place_key(logic [KEY_W-1:0] k, logic [PW_W-1:0] pw);
        int unsigned idx;
        int unsigned stride;
        idx    = int'(k) % TABLE_SIZE;
        stride = probe_stride(k);
        for (int n = 0; n < TABLE_SIZE; n++) begin
            if (shadow_mark[idx] != MARK_USED) begin
                shadow_mark[idx]    = MARK_USED;
                shadow_key[idx]     = k;
                shadow_value[idx]   = pw;
                shadow_session[idx] = 1'b0;
                return;
            end
            idx = (idx + stride) % TABLE_SIZE;
        end
    endfunction

    // Apply one request to the shadow table and queue its result, if any
    function automatic void apply_request(t_in req);
        int   slot;
        t_out res;
        slot = find_slot(req.key);
        res  = '0;
        case (req.kind)
            KIND_SIGNUP: begin
                if (slot >= 0) begin
                    res.status = ST_INVALID;
                end else begin
                    place_key(req.key, req.password);
                    res.status = ST_SUBMIT;
                end
            end
            KIND_LOGIN: begin
                if (slot < 0 || shadow_value[slot] != req.password) begin
                    res.status = ST_INVALID;
                end else if (shadow_session[slot]) begin
                    res.status = ST_QUIT;
                end else begin
                    shadow_session[slot] = 1'b1;
                    res.status = ST_SUBMIT;
                end
            end
            KIND_LOGOUT: begin
                if (slot < 0) return;
                shadow_session[slot] = 1'b0;
                res.status = ST_SUBMIT;
            end
            default: begin
                if (slot < 0) begin
                    res.status = ST_NONE;
                end else begin
                    res.status           = ST_REMOVED;
                    res.value_out        = shadow_value[slot];
                    shadow_mark[slot]    = MARK_DELETED;
                    shadow_session[slot] = 1'b0;
                end
            end
        endcase
        expected_results.push_back(res);
    endfunction

    function automatic void flag_mismatch(string what, t_out exp_r, t_out act_r);
        if (o_errors < 10)
            $display("%0t: %s: expected status %0d value %h, got status %0d value %h",
                     $realtime, what, exp_r.status, exp_r.value_out,
                     act_r.status, act_r.value_out);
        o_errors++;
    endfunction

    // Sample every channel at the clock edge
    always @(posedge i_clk) begin
        t_out exp_r;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_SIZE; i++) begin
                shadow_mark[i]    = MARK_EMPTY;
                shadow_session[i] = 1'b0;
                shadow_key[i]     = '0;
                shadow_value[i]   = '0;
            end
            shadow_q = Q_RESET;
            expected_results.delete();
            o_errors  = 0;
            o_results = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (expected_results.size() == 0) begin
                    flag_mismatch("result with nothing pending", '0, i_out_data);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.status != i_out_data.status ||
                        exp_r.value_out != i_out_data.value_out)
                        flag_mismatch("result mismatch", exp_r, i_out_data);
                end
            end
            if (i_cfg_valid && i_cfg_ready) shadow_q = i_cfg_data;
            if (i_in_valid && !i_in_stall) apply_request(i_in_data);
        end
        o_pending = expected_results.size();
    end

endmodule
`default_nettype wire

@@ test/tb_double_hash_session_table.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_double_hash_session_table;
    import dhst_pkg::*;

    localparam int POOL_N      = 48;
    localparam int PHASE_ITEMS = 100;
    localparam int CALM_ITEMS  = 50;
    localparam int SETTLE_CYC  = 2200;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_stall;
    t_in            in_data = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    t_out           out_data;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [Q_W-1:0] cfg_data = '0;
    int             pending;
    int             errors;
    int             results;

    bit               idling_on = 1'b1;
    int               requests_sent = 0;
    logic [KEY_W-1:0] user_key [POOL_N];
    logic [PW_W-1:0]  user_pw  [POOL_N];

    always #2 clk = ~clk;

    double_hash_session_table u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    dhst_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_errors    (errors),
        .o_results   (results)
    );

    // Hold off the result channel in random bursts
    always begin
        @(posedge clk);
        if (idling_on && $urandom_range(0, 9) == 0) begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    function automatic logic [PW_W-1:0] rand_pw();
        return {$urandom, $urandom};
    endfunction

    // Offer one request, with an optional gap first
    task automatic send(input logic [1:0] kind, input logic [KEY_W-1:0] key,
                        input logic [PW_W-1:0] pw);
        if (idling_on && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        in_data.kind     <= kind;
        in_data.key      <= key;
        in_data.password <= pw;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        requests_sent++;
    endtask

    // Wait until every result is back, then let a logout miss finish
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_step(input logic [Q_W-1:0] q);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= q;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed traffic on known users, some noise
    task automatic random_traffic(input int count);
        int               r;
        int               u;
        logic [1:0]       kind;
        logic [PW_W-1:0]  pw;
        for (int i = 0; i < count; i++) begin
            r    = $urandom_range(0, 99);
            u    = $urandom_range(0, POOL_N - 1);
            kind = 2'($urandom_range(0, 3));
            if (r < 10) begin
                send(kind, KEY_W'($urandom), rand_pw());
            end else if (kind == KIND_SIGNUP) begin
                pw = rand_pw();
                user_pw[u] = pw;
                send(kind, user_key[u], pw);
            end else begin
                pw = (r < 18) ? rand_pw() : user_pw[u];
                send(kind, user_key[u], pw);
            end
        end
    endtask

    initial begin
        int unsigned base;
        logic [KEY_W-1:0] kmax;
        kmax = '1;
        base = $urandom_range(0, TABLE_SIZE - 1);
        // Users: a third share one home slot, the rest spread over the key range
        for (int i = 0; i < POOL_N; i++) begin
            user_key[i] = (i % 3 == 0) ? KEY_W'(base + i * TABLE_SIZE) : KEY_W'($urandom);
            user_pw[i]  = rand_pw();
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, every operation, collisions and slot reuse
        send(KIND_SIGNUP, '0, '0);
        send(KIND_SIGNUP, kmax, '1);
        send(KIND_SIGNUP, '0, '1);
        send(KIND_LOGIN,  '0, '0);
        send(KIND_LOGIN,  '0, '0);
        send(KIND_LOGIN,  kmax, '0);
        send(KIND_LOGIN,  KEY_W'(5), '0);
        send(KIND_LOGOUT, '0, '0);
        send(KIND_LOGOUT, KEY_W'(5), '0);
        send(KIND_LOGIN,  '0, '0);
        send(KIND_REMOVE, kmax, '0);
        send(KIND_REMOVE, kmax, '0);
        send(KIND_SIGNUP, KEY_W'(TABLE_SIZE), 64'h5555_5555_5555_5555);
        send(KIND_SIGNUP, KEY_W'(2 * TABLE_SIZE), 64'hAAAA_AAAA_AAAA_AAAA);
        send(KIND_REMOVE, KEY_W'(TABLE_SIZE), '0);
        send(KIND_SIGNUP, KEY_W'(3 * TABLE_SIZE), 64'h0123_4567_89AB_CDEF);
        send(KIND_LOGIN,  KEY_W'(2 * TABLE_SIZE), 64'hAAAA_AAAA_AAAA_AAAA);
        send(KIND_REMOVE, KEY_W'(3 * TABLE_SIZE), '0);
        send(KIND_REMOVE, '0, '0);

        // Random phases over several step settings
        random_traffic(PHASE_ITEMS);
        write_step(Q_W'(1));
        random_traffic(PHASE_ITEMS);
        write_step(Q_W'(1020));
        random_traffic(PHASE_ITEMS);
        write_step('0);
        random_traffic(PHASE_ITEMS);
        write_step(Q_W'($urandom_range(2, 1019)));
        random_traffic(PHASE_ITEMS - CALM_ITEMS);
        idling_on = 1'b0;
        random_traffic(CALM_ITEMS);

        // Fill the table to overflow with unit step, then probe a full table
        write_step(Q_W'(1));
        for (int k = 0; k < TABLE_SIZE + 4; k++)
            send(KIND_SIGNUP, KEY_W'(k + 100000), PW_W'(k));
        send(KIND_LOGIN,  KEY_W'(100005), PW_W'(5));
        send(KIND_LOGOUT, KEY_W'(100005), '0);
        send(KIND_REMOVE, KEY_W'(100005), '0);
        send(KIND_SIGNUP, KEY_W'(7777777), 64'hFEED_0000_0000_BEEF);
        send(KIND_REMOVE, KEY_W'(7777777), '0);
        send(KIND_REMOVE, KEY_W'(9999999), '0);

        drain();
        $display("Covered %0d requests and %0d results over step settings 7, 1, 1020, 0",
                 requests_sent, results);
        $display("and one random value, ending with an overfilled table.");
        if (errors == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #100ms;
        $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire
